// File: design/touch_stroke_point_filter_macros.svh
// ----------------------------------------------------------------------------
// Touch stroke point filter assertion macros
// Shorthand for the clocked, reset-qualified assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_STROKE_POINT_FILTER_MACROS_SVH
`define TOUCH_STROKE_POINT_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tspf_pkg.sv
// ----------------------------------------------------------------------------
// Touch stroke point filter package
// Shared constants, register indexes and operation codes.
// ----------------------------------------------------------------------------
package tspf_pkg;

  localparam int DEF_SCREEN_COORD_BITS = 12;
  localparam int DEF_CANVAS_COORD_BITS = 10;

  // Register reset values.
  localparam int RST_CANVAS_W    = 60;
  localparam int RST_CANVAS_H    = 35;
  localparam int RST_DISPLAY_W   = 480;
  localparam int RST_DISPLAY_H   = 320;
  localparam int RST_MIN_DIST_SQ = 100;
  localparam int RST_MAX_DIST_SQ = 1600;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_W    = 3'd0,
    REG_CANVAS_H    = 3'd1,
    REG_DISPLAY_W   = 3'd2,
    REG_DISPLAY_H   = 3'd3,
    REG_MIN_DIST_SQ = 3'd4,
    REG_MAX_DIST_SQ = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_POINT    = 1'b0,
    OP_NEW_LINE = 1'b1
  } op_t;

endpackage

// File: design/tspf_if.sv
// ----------------------------------------------------------------------------
// Touch stroke point filter channels
// Valid/ready channels for touch items and emitted stroke points.
// ----------------------------------------------------------------------------
interface tspf_in_if #(
  parameter int SCREEN_COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [SCREEN_COORD_BITS-1:0] touch_x;
  logic [SCREEN_COORD_BITS-1:0] touch_y;

  modport source (output valid, output operation, output touch_x, output touch_y,
                  input ready);
  modport sink   (input valid, input operation, input touch_x, input touch_y,
                  output ready);
endinterface

interface tspf_out_if #(
  parameter int SCREEN_COORD_BITS = 12,
  parameter int CANVAS_COORD_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic [CANVAS_COORD_BITS-1:0] plot_x;
  logic [CANVAS_COORD_BITS-1:0] plot_y;
  logic                         pen_up;
  logic                         draw_line;
  logic [SCREEN_COORD_BITS-1:0] line_from_x;
  logic [SCREEN_COORD_BITS-1:0] line_from_y;

  modport source (output valid, output plot_x, output plot_y, output pen_up,
                  output draw_line, output line_from_x, output line_from_y,
                  input ready);
  modport sink   (input valid, input plot_x, input plot_y, input pen_up,
                  input draw_line, input line_from_x, input line_from_y,
                  output ready);
endinterface

// File: design/tspf_divider.sv
// ----------------------------------------------------------------------------
// Touch stroke point filter divider
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tspf_divider #(
  parameter int SB = 12,
  parameter int CB = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SB+CB-1:0] dividend,
  input  logic [SB-1:0]    divisor,
  output logic             done,
  output logic [CB-1:0]    quotient
);

  localparam int CNTW = $clog2(CB);

  // The caller guarantees dividend < divisor << CB, so the upper part already
  // sits below the divisor and only CB steps are needed.
  logic [SB-1:0]   rem_r;
  logic [CB-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [SB:0]     trial;
  logic [SB:0]     diff;
  logic            ge;

  assign trial = {rem_r, quo_r[CB-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend[SB+CB-1:CB];
        quo_r  <= dividend[CB-1:0];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[SB-1:0] : trial[SB-1:0];
        quo_r <= {quo_r[CB-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(CB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/touch_stroke_point_filter.sv
// ----------------------------------------------------------------------------
// Touch stroke point filter
// Maps touch points to canvas coordinates and thins them into pen moves.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Carries
//   in_ch    input      valid/ready         operation, touch_x, touch_y
//   out_ch   output     valid/ready         canvas point, pen and segment info
//   cfg_*    input      write enable only   six configuration registers
//
// A touch point is mapped by the shared divider, which produces one quotient
// bit per cycle and is run once per axis, and by the single shared
// multiplier used for both products and both squares. A new-line item
// completes in its transfer cycle. Reset is synchronous and restores the
// register defaults and the stroke state. A stalled result holds the next
// point in its final step until the output register frees up; new items
// are taken only while the sequencer is idle.
//
module touch_stroke_point_filter
  import tspf_pkg::*;
#(
  parameter int SCREEN_COORD_BITS = DEF_SCREEN_COORD_BITS,
  parameter int CANVAS_COORD_BITS = DEF_CANVAS_COORD_BITS,
  localparam int DIST_W = 2 * CANVAS_COORD_BITS + 1,
  localparam int CFG_DW = (DIST_W > SCREEN_COORD_BITS) ? DIST_W : SCREEN_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tspf_in_if.sink              in_ch,
  tspf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  localparam int SB  = SCREEN_COORD_BITS;
  localparam int CB  = CANVAS_COORD_BITS;
  localparam int OPW = (SB > CB) ? SB : CB;
  localparam int PW  = OPW + CB;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIVS = 8'b0000_0100,
    S_DIVW = 8'b0000_1000,
    S_SQX  = 8'b0001_0000,
    S_SQY  = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CB-1:0]     cw_r, ch_r;
  logic [SB-1:0]     dw_r, dh_r;
  logic [DIST_W-1:0] min_r, max_r;

  // Working registers of the current point.
  logic [SB-1:0]     dx_r, dy_r;
  logic              axis_r;       // 0 maps canvas x, 1 maps canvas y
  logic [PW-1:0]     prod_r;
  logic              clamp_r;
  logic              zero_r;
  logic [CB-1:0]     cx_r, cy_r;
  logic [DIST_W-1:0] acc_r;

  // Stroke state.
  logic [CB-1:0]     last_cx_r, last_cy_r;
  logic [SB-1:0]     last_sx_r, last_sy_r;
  logic              pending_r;

  // Result register.
  logic              out_valid_r;
  logic [CB-1:0]     out_cx_r, out_cy_r;
  logic              out_pen_up_r;
  logic              out_draw_r;
  logic [SB-1:0]     out_fx_r, out_fy_r;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_free;
  logic              emit_now;

  logic [SB-1:0]     cur_coord;
  logic [CB-1:0]     cur_size;
  logic [SB-1:0]     cur_div;
  logic [CB-1:0]     adx, ady;
  logic [OPW-1:0]    mul_a;
  logic [CB-1:0]     mul_b;
  logic [PW-1:0]     mul_p;
  logic [CB-1:0]     map_val;

  logic              div_start;
  logic              div_done;
  logic [CB-1:0]     div_quot;

  logic              over_min;
  logic              over_max;
  logic              record;
  logic              draw_now;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Canvas x comes from the display y axis and canvas y from display x.
  assign cur_coord = axis_r ? dx_r : dy_r;
  assign cur_size  = axis_r ? ch_r : cw_r;
  assign cur_div   = axis_r ? dh_r : dw_r;

  assign adx = (cx_r >= last_cx_r) ? (cx_r - last_cx_r) : (last_cx_r - cx_r);
  assign ady = (cy_r >= last_cy_r) ? (cy_r - last_cy_r) : (last_cy_r - cy_r);

  // The one multiplier: coordinate times canvas size, then the two squares.
  always_comb begin
    mul_a = OPW'(cur_coord);
    mul_b = cur_size;
    if (state_r == S_SQX) begin
      mul_a = OPW'(adx);
      mul_b = adx;
    end else if (state_r == S_SQY) begin
      mul_a = OPW'(ady);
      mul_b = ady;
    end
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // The quotient reaches the canvas size exactly when the coordinate reaches
  // the divisor, which also covers a zero divisor. Below that the quotient
  // is known to fit the canvas width, so the divider needs only CB steps.
  assign map_val = zero_r  ? '0 :
                   clamp_r ? (cur_size - 1'b1) : div_quot;

  assign div_start = (state_r == S_DIVS);

  tspf_divider #(
    .SB (SB),
    .CB (CB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[SB+CB-1:0]),
    .divisor  (cur_div),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Stroke decision. A line start is always taken with the pen up; later
  // points must clear the minimum distance, and a jump beyond the maximum
  // is made with the pen up as well.
  assign over_min = acc_r > min_r;
  assign over_max = acc_r > max_r;
  assign record   = pending_r || over_min;
  assign draw_now = !pending_r && over_min && !over_max;

  // The result register is loaded in the final step once it is free.
  assign emit_now = (state_r == S_EMIT) && record && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_ch.operation == OP_POINT) state_nxt = S_MUL;
      end
      S_MUL:  state_nxt = S_DIVS;
      S_DIVS: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) state_nxt = axis_r ? S_SQX : S_MUL;
      end
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (!record || out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cw_r        <= CB'(RST_CANVAS_W);
      ch_r        <= CB'(RST_CANVAS_H);
      dw_r        <= SB'(RST_DISPLAY_W);
      dh_r        <= SB'(RST_DISPLAY_H);
      min_r       <= DIST_W'(RST_MIN_DIST_SQ);
      max_r       <= DIST_W'(RST_MAX_DIST_SQ);
      last_cx_r   <= '0;
      last_cy_r   <= '0;
      last_sx_r   <= '0;
      last_sy_r   <= '0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CANVAS_W:    cw_r  <= cfg_data[CB-1:0];
          REG_CANVAS_H:    ch_r  <= cfg_data[CB-1:0];
          REG_DISPLAY_W:   dw_r  <= cfg_data[SB-1:0];
          REG_DISPLAY_H:   dh_r  <= cfg_data[SB-1:0];
          REG_MIN_DIST_SQ: min_r <= cfg_data[DIST_W-1:0];
          REG_MAX_DIST_SQ: max_r <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end

      // A new result may replace one that leaves in the same cycle.
      if (emit_now) out_valid_r <= 1'b1;
      else if (out_xfer) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.operation == OP_NEW_LINE) begin
              pending_r <= 1'b1;
            end else begin
              dx_r   <= in_ch.touch_x;
              dy_r   <= in_ch.touch_y;
              axis_r <= 1'b0;
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_p;
          clamp_r <= cur_coord >= cur_div;
          zero_r  <= cur_size == '0;
        end
        S_DIVW: begin
          if (div_done) begin
            if (axis_r) cy_r <= map_val;
            else        cx_r <= map_val;
            axis_r <= 1'b1;
          end
        end
        S_SQX: begin
          prod_r <= mul_p;
        end
        S_SQY: begin
          prod_r <= mul_p;
          acc_r  <= DIST_W'(prod_r);
        end
        S_ADD: begin
          acc_r <= acc_r + DIST_W'(prod_r);
        end
        S_EMIT: begin
          // Every recorded point, pen up or down, leaves no line start pending.
          if (emit_now) begin
            out_cx_r     <= cx_r;
            out_cy_r     <= cy_r;
            out_pen_up_r <= !draw_now;
            out_draw_r   <= draw_now;
            out_fx_r     <= draw_now ? last_sx_r : '0;
            out_fy_r     <= draw_now ? last_sy_r : '0;
            last_cx_r    <= cx_r;
            last_cy_r    <= cy_r;
            last_sx_r    <= dx_r;
            last_sy_r    <= dy_r;
            pending_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.plot_x      = out_cx_r;
  assign out_ch.plot_y      = out_cy_r;
  assign out_ch.pen_up      = out_pen_up_r;
  assign out_ch.draw_line   = out_draw_r;
  assign out_ch.line_from_x = out_fx_r;
  assign out_ch.line_from_y = out_fy_r;

endmodule

// File: design/tspf_checker.sv
// ----------------------------------------------------------------------------
// Touch stroke point filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_stroke_point_filter_macros.svh"

module tspf_checker
  import tspf_pkg::*;
#(
  parameter int SB = 12,
  parameter int CB = 10
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          in_operation,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CB-1:0] out_plot_x,
  input logic [CB-1:0] out_plot_y,
  input logic          out_pen_up,
  input logic          out_draw_line,
  input logic [SB-1:0] out_line_from_x,
  input logic [SB-1:0] out_line_from_y
);

  // A pen-up move never asks for a segment, and a pen-down move always does.
  `TSPF_ASSERT_IMP(a_pen_vs_segment, clk, rst_n, out_valid, (out_pen_up != out_draw_line) && (out_draw_line || (out_line_from_x == '0 && out_line_from_y == '0)), "pen and segment fields disagree")

  // Clamping keeps canvas coordinates below the largest canvas size.
  `TSPF_ASSERT_IMP(a_canvas_clamped, clk, rst_n, out_valid, out_plot_x != '1 && out_plot_y != '1, "canvas coordinate escaped the clamp")

  // A touch point keeps the block busy for its whole mapping.
  `TSPF_ASSERT_NXT(a_point_busy, clk, rst_n, in_valid && in_ready && in_operation == OP_POINT, !in_ready, "block ready right after a touch point")

  // A stalled result stays in place.
  `TSPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_plot_x) && $stable(out_plot_y) && $stable(out_pen_up), "stalled result changed")

endmodule

bind touch_stroke_point_filter tspf_checker #(
  .SB (SCREEN_COORD_BITS),
  .CB (CANVAS_COORD_BITS)
) u_tspf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_operation    (in_ch.operation),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_plot_x      (out_ch.plot_x),
  .out_plot_y      (out_ch.plot_y),
  .out_pen_up      (out_ch.pen_up),
  .out_draw_line   (out_ch.draw_line),
  .out_line_from_x (out_ch.line_from_x),
  .out_line_from_y (out_ch.line_from_y)
);
